>>> src/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants of the client readiness scoreboard
// Holds the request and response formats, the command codes, the sequencer
// states and the control and status groups between the top level and the
// bitmap store.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int MAX_CLIENTS = 64;
    localparam int CLIENT_W    = $clog2(MAX_CLIENTS);
    localparam int COUNT_W     = $clog2(MAX_CLIENTS + 1);
    localparam int KIND_W      = 3;
    localparam int LIMIT_W     = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_CLIENTS);

    // Command codes carried in the kind field of a request.
    localparam logic [KIND_W-1:0] KIND_CONNECT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DISCONNECT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READY      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESET_ALL  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_LIST       = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_REPLY,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CLIENT_W-1:0] client;
        logic [LIMIT_W-1:0]  list_limit;
    } req_t;

    typedef struct packed {
        logic                applied;
        logic                missing_valid;
        logic [CLIENT_W-1:0] missing_client;
        logic                last;
        logic                all_ready;
        logic [COUNT_W-1:0]  ready_count;
        logic [COUNT_W-1:0]  connected_count;
    } rsp_t;

    // Command from the sequencer to the bitmap store.
    typedef struct packed {
        logic                apply;
        logic [KIND_W-1:0]   kind;
        logic [CLIENT_W-1:0] client;
        logic                in_range;
    } map_cmd_t;

    // Status from the bitmap store back to the sequencer.
    typedef struct packed {
        logic               applied;
        logic               probe_ready;
        logic               all_ready;
        logic [COUNT_W-1:0] ready_count;
        logic [COUNT_W-1:0] conn_count;
    } map_stat_t;

endpackage

>>> src/crs_maps.sv
// ----------------------------------------------------------------------------
// crs_maps: connected and ready bitmaps with running population counts
// Applies one command per strobe and answers the single-bit probe that the
// list scan steps through, plus the all-ready flag over the active clients.
// ----------------------------------------------------------------------------
module crs_maps
    import crs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  map_cmd_t               cmd,
    input  logic [CLIENT_W-1:0]    probe_idx,
    input  logic [MAX_CLIENTS-1:0] active_mask,
    input  logic                   active_any,
    output map_stat_t              stat
);

    logic [MAX_CLIENTS-1:0] conn_map_reg;
    logic [MAX_CLIENTS-1:0] conn_map_next;
    logic [MAX_CLIENTS-1:0] ready_map_reg;
    logic [MAX_CLIENTS-1:0] ready_map_next;
    logic [COUNT_W-1:0]     conn_cnt_reg;
    logic [COUNT_W-1:0]     conn_cnt_next;
    logic [COUNT_W-1:0]     ready_cnt_reg;
    logic [COUNT_W-1:0]     ready_cnt_next;
    logic                   conn_bit;
    logic                   ready_bit;
    logic                   applied;

    assign conn_bit  = conn_map_reg[cmd.client];
    assign ready_bit = ready_map_reg[cmd.client];

    always_comb
    begin
        case (cmd.kind)
            KIND_CONNECT:    applied = cmd.in_range;
            KIND_DISCONNECT: applied = cmd.in_range;
            KIND_CLEAR:      applied = cmd.in_range;
            KIND_READY:      applied = cmd.in_range && conn_bit;
            KIND_RESET_ALL:  applied = 1'b1;
            default:         applied = 1'b0;
        endcase
    end

    // A ready bit is only ever set on a connected client, so the ready map
    // stays a subset of the connected map and the counts move by one.
    always_comb
    begin
        conn_map_next  = conn_map_reg;
        ready_map_next = ready_map_reg;
        conn_cnt_next  = conn_cnt_reg;
        ready_cnt_next = ready_cnt_reg;
        if (cmd.apply && applied)
        begin
            case (cmd.kind)
                KIND_CONNECT:
                begin
                    conn_map_next[cmd.client] = 1'b1;
                    if (!conn_bit)
                        conn_cnt_next = conn_cnt_reg + COUNT_W'(1);
                end
                KIND_DISCONNECT, KIND_CLEAR:
                begin
                    conn_map_next[cmd.client]  = 1'b0;
                    ready_map_next[cmd.client] = 1'b0;
                    if (conn_bit)
                        conn_cnt_next = conn_cnt_reg - COUNT_W'(1);
                    if (ready_bit)
                        ready_cnt_next = ready_cnt_reg - COUNT_W'(1);
                end
                KIND_READY:
                begin
                    ready_map_next[cmd.client] = 1'b1;
                    if (!ready_bit)
                        ready_cnt_next = ready_cnt_reg + COUNT_W'(1);
                end
                KIND_RESET_ALL:
                begin
                    conn_map_next  = '0;
                    ready_map_next = '0;
                    conn_cnt_next  = '0;
                    ready_cnt_next = '0;
                end
                default:
                begin
                    conn_map_next = conn_map_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_map_reg  <= '0;
            ready_map_reg <= '0;
            conn_cnt_reg  <= '0;
            ready_cnt_reg <= '0;
        end
        else
        begin
            conn_map_reg  <= conn_map_next;
            ready_map_reg <= ready_map_next;
            conn_cnt_reg  <= conn_cnt_next;
            ready_cnt_reg <= ready_cnt_next;
        end
    end

    assign stat.applied     = applied;
    assign stat.probe_ready = ready_map_reg[probe_idx];
    assign stat.all_ready   = active_any && ((ready_map_reg & active_mask) == active_mask);
    assign stat.ready_count = ready_cnt_reg;
    assign stat.conn_count  = conn_cnt_reg;

endmodule

>>> src/client_readiness_scoreboard_unit.sv
// ----------------------------------------------------------------------------
// client_readiness_scoreboard_unit: per-client connected and ready tracking
// Takes connect, disconnect, ready, clear, reset-all and list-missing
// requests and answers each with one response, or one response per missing
// client for a list request.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload    Direction
//  req       req_valid/req_stall  req_data   into the block
//  rsp       rsp_valid/rsp_stall  rsp_data   out of the block
//  cfg       cfg_valid/cfg_ready  cfg_data   into the block (client count)
//
// A non-list request, once accepted, passes through the apply state, which
// applies it to the bitmaps, and the reply state, which loads the response
// once the response register is free, and then returns to idle, where the
// next request is taken. A list request steps the single-bit probe through
// one client index per cycle unless a stalled response holds it, and
// ends at the active count or the limit; each index that it reports waits
// for the response register to be free. Reset clears both bitmaps, both
// counts and the response valid flag, and sets the client count to its
// maximum. A stalled response holds the scan, but a request can be
// accepted in the idle state while the previous response still waits.
//
module client_readiness_scoreboard_unit
    import crs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_t               req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_t               rsp_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    state_t                 state_reg;
    state_t                 state_next;
    req_t                   req_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     active_n;
    logic [MAX_CLIENTS-1:0] active_mask;
    logic [COUNT_W-1:0]     scan_reg;
    logic [LIMIT_W-1:0]     found_reg;
    logic                   pend_valid_reg;
    logic [CLIENT_W-1:0]    pend_idx_reg;
    logic                   applied_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;
    map_cmd_t               map_cmd;
    map_stat_t              map_stat;
    logic                   req_take;
    logic                   out_free;
    logic                   scan_done;
    logic                   push;
    rsp_t                   push_data;
    logic                   scan_step;
    logic                   take_pend;
    logic                   map_apply;

    // The active client count saturates at the table size; the register holds the written value.
    assign active_n = (count_reg > COUNT_MAX) ? COUNT_MAX : count_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_CLIENTS; i++)
        begin
            active_mask[i] = (COUNT_W'(i) < active_n);
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // The scan ends at the active count or once the limit has been reached.
    assign scan_done = (scan_reg >= active_n) || (found_reg == req_reg.list_limit);

    assign map_cmd.apply    = map_apply;
    assign map_cmd.kind     = req_reg.kind;
    assign map_cmd.client   = req_reg.client;
    assign map_cmd.in_range = ({1'b0, req_reg.client} < active_n);

    crs_maps u_maps
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (map_cmd),
        .probe_idx   (scan_reg[CLIENT_W-1:0]),
        .active_mask (active_mask),
        .active_any  (active_n != '0),
        .stat        (map_stat)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                    state_next = (req_data.kind == KIND_LIST) ? ST_SCAN : ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_done && out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs. A found index is held back one step so that the
    // last flag is known when it goes out: it leaves as a non-final response
    // when the next missing index turns up, or as the final one at the end.
    always_comb
    begin
        push                      = 1'b0;
        scan_step                 = 1'b0;
        take_pend                 = 1'b0;
        map_apply                 = 1'b0;
        push_data.applied         = 1'b1;
        push_data.missing_valid   = 1'b0;
        push_data.missing_client  = '0;
        push_data.last            = 1'b1;
        push_data.all_ready       = map_stat.all_ready;
        push_data.ready_count     = map_stat.ready_count;
        push_data.connected_count = map_stat.conn_count;
        case (state_reg)
            ST_IDLE:
            begin
                push = 1'b0;
            end
            ST_APPLY:
            begin
                map_apply = 1'b1;
            end
            ST_REPLY:
            begin
                push              = out_free;
                push_data.applied = applied_reg;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    push                    = out_free;
                    push_data.missing_valid = pend_valid_reg;
                    push_data.missing_client =
                        pend_valid_reg ? pend_idx_reg : '0;
                end
                else if (!map_stat.probe_ready)
                begin
                    if (!pend_valid_reg)
                    begin
                        take_pend = 1'b1;
                        scan_step = 1'b1;
                    end
                    else if (out_free)
                    begin
                        push                     = 1'b1;
                        push_data.missing_valid  = 1'b1;
                        push_data.missing_client = pend_idx_reg;
                        push_data.last           = 1'b0;
                        take_pend                = 1'b1;
                        scan_step                = 1'b1;
                    end
                end
                else
                begin
                    scan_step = 1'b1;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= COUNT_MAX;
            scan_reg       <= '0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
            applied_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_data;
            if (req_take)
            begin
                scan_reg       <= '0;
                found_reg      <= '0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (scan_step)
                    scan_reg <= scan_reg + COUNT_W'(1);
                if (take_pend)
                begin
                    found_reg      <= found_reg + LIMIT_W'(1);
                    pend_valid_reg <= 1'b1;
                end
            end
            if (map_apply)
                applied_reg <= map_stat.applied;
            if (push)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            req_reg <= req_data;
        if (take_pend)
            pend_idx_reg <= scan_reg[CLIENT_W-1:0];
        if (push)
            rsp_reg <= push_data;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // The held index always lies behind the scan position.
    a_pend_behind_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && pend_valid_reg) |-> ({1'b0, pend_idx_reg} < scan_reg))
        else $error("held missing index is not behind the scan position");

    // The scan never finds more indices than the request allows.
    a_found_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (found_reg <= req_reg.list_limit))
        else $error("list scan found more indices than its limit");

    // A reported missing index only comes from an applied list request.
    a_missing_applied: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.missing_valid) |-> rsp_reg.applied)
        else $error("missing index reported on an ignored request");

    // Ready clients are always a subset of connected clients.
    a_ready_le_connected: assert property (@(posedge clk) disable iff (!rst_n)
        map_stat.ready_count <= map_stat.conn_count)
        else $error("ready count exceeds connected count");

    // A non-final list response is always followed by more of the same list.
    a_scan_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !push_data.last) |=> (state_reg == ST_SCAN))
        else $error("list ended after a response without the last flag");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the client readiness scoreboard
// Drives command requests through the valid/stall request channel, writes the
// client count through the configuration channel between phases, and checks
// every response against a cycle-free model of the connected and ready maps.
// Idle and stall patterns on both sides change between phases, and one phase
// holds the response side off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
    import crs_pkg::*;

    // Kind codes that the block must ignore.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRINT_LIMIT   = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    req_t               req_data = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rsp_t               rsp_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data = '0;

    client_readiness_scoreboard_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock: 2 ns high, 2 ns low.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the scoreboard state and its client count register.
    logic [63:0]        shadow_conn  = '0;
    logic [63:0]        shadow_ready = '0;
    logic [COUNT_W-1:0] shadow_count = COUNT_MAX;

    // Responses that the block still owes, oldest first.
    rsp_t owed_rsp_q[$];

    int send_idle_pct = 0;
    int rcv_idle_pct  = 0;
    bit rsp_hold      = 1'b0;

    int cycle_cnt      = 0;
    int errors         = 0;
    int requests_sent  = 0;
    int rsp_checked    = 0;
    int missing_seen   = 0;

    // ------------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------------
    function automatic int active_clients();
        return (shadow_count > COUNT_MAX) ? MAX_CLIENTS : int'(shadow_count);
    endfunction

    // Builds one response from the current shadow state.
    function automatic rsp_t shadow_rsp(input logic applied, input logic mvalid,
                                        input logic [CLIENT_W-1:0] idx, input logic last);
        rsp_t        r;
        logic [63:0] mask;
        int          n;
        n    = active_clients();
        mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        r.applied         = applied;
        r.missing_valid   = mvalid;
        r.missing_client  = idx;
        r.last            = last;
        r.all_ready       = (n != 0) && ((shadow_ready & mask) == mask);
        r.ready_count     = COUNT_W'($countones(shadow_ready));
        r.connected_count = COUNT_W'($countones(shadow_conn));
        return r;
    endfunction

    // Applies one accepted request to the shadow maps and queues the
    // responses that it must produce.
    function automatic void predict_response(input req_t r);
        int    n;
        bit    in_range;
        logic  applied;
        int    missing[$];
        n        = active_clients();
        in_range = int'(r.client) < n;
        applied  = 1'b0;
        case (r.kind)
            KIND_CONNECT:
            begin
                if (in_range)
                begin
                    shadow_conn[r.client] = 1'b1;
                    applied = 1'b1;
                end
            end
            KIND_DISCONNECT, KIND_CLEAR:
            begin
                // Dropping the connection always drops readiness with it.
                if (in_range)
                begin
                    shadow_conn[r.client]  = 1'b0;
                    shadow_ready[r.client] = 1'b0;
                    applied = 1'b1;
                end
            end
            KIND_READY:
            begin
                if (in_range && shadow_conn[r.client])
                begin
                    shadow_ready[r.client] = 1'b1;
                    applied = 1'b1;
                end
            end
            KIND_RESET_ALL:
            begin
                shadow_conn  = '0;
                shadow_ready = '0;
                applied = 1'b1;
            end
            KIND_LIST:
            begin
                for (int i = 0; i < n && missing.size() < int'(r.list_limit); i++)
                begin
                    if (!shadow_ready[i])
                        missing.push_back(i);
                end
                if (missing.size() == 0)
                    owed_rsp_q.push_back(shadow_rsp(1'b1, 1'b0, '0, 1'b1));
                for (int k = 0; k < missing.size(); k++)
                begin
                    owed_rsp_q.push_back(shadow_rsp(1'b1, 1'b1, CLIENT_W'(missing[k]),
                                                    k == missing.size() - 1));
                end
                return;
            end
            default:
            begin
            end
        endcase
        owed_rsp_q.push_back(shadow_rsp(applied, 1'b0, '0, 1'b1));
    endfunction

    // ------------------------------------------------------------------------
    // Response side: stall pattern and checking
    // ------------------------------------------------------------------------
    always @(negedge clk)
        rsp_stall <= rsp_hold || ($urandom_range(99) < rcv_idle_pct);

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s is %0d, expected %0d",
                     cycle_cnt, what, got, want);
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (owed_rsp_q.size() == 0)
                report_mismatch("response with nothing owed, applied", rsp_data.applied, 0);
            else
            begin
                want = owed_rsp_q.pop_front();
                rsp_checked++;
                if (rsp_data.missing_valid)
                    missing_seen++;
                if (rsp_data.applied !== want.applied)
                    report_mismatch("applied", rsp_data.applied, want.applied);
                if (rsp_data.missing_valid !== want.missing_valid)
                    report_mismatch("missing_valid", rsp_data.missing_valid,
                                    want.missing_valid);
                if (rsp_data.missing_client !== want.missing_client)
                    report_mismatch("missing_client", rsp_data.missing_client,
                                    want.missing_client);
                if (rsp_data.last !== want.last)
                    report_mismatch("last", rsp_data.last, want.last);
                if (rsp_data.all_ready !== want.all_ready)
                    report_mismatch("all_ready", rsp_data.all_ready, want.all_ready);
                if (rsp_data.ready_count !== want.ready_count)
                    report_mismatch("ready_count", rsp_data.ready_count, want.ready_count);
                if (rsp_data.connected_count !== want.connected_count)
                    report_mismatch("connected_count", rsp_data.connected_count,
                                    want.connected_count);
            end
        end
    end

    // Watchdog: ends a run that hangs.
    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d responses still owed",
                 cycle_cnt, owed_rsp_q.size());
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    function automatic req_t make_req(input logic [KIND_W-1:0] kind, input int client,
                                      input int limit);
        req_t r;
        r.kind       = kind;
        r.client     = CLIENT_W'(client);
        r.list_limit = LIMIT_W'(limit);
        return r;
    endfunction

    // Offers one request, starting at a falling edge, and returns at a falling
    // edge after it was taken. Valid stays high when no idle gap follows, so
    // the next call simply replaces the payload.
    task automatic send_request(input req_t r);
        req_data  <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_response(r);
        requests_sent++;
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic release_request();
        req_valid <= 1'b0;
    endtask

    // Waits until every owed response has arrived, then lets the block settle.
    task automatic wait_drain();
        while (owed_rsp_q.size() != 0)
            @(posedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Writes the client count register while the block is idle.
    task automatic set_client_count(input int value);
        wait_drain();
        cfg_data  <= COUNT_W'(value);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_count = COUNT_W'(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t random_request(input int n);
        req_t r;
        int   sel;
        int   lsel;
        sel  = $urandom_range(99);
        lsel = $urandom_range(99);
        if ($urandom_range(99) < 85 && n > 0)
            r.client = CLIENT_W'($urandom_range(n - 1));
        else
            r.client = CLIENT_W'($urandom_range(63));
        // Mostly short lists; now and then the whole range, or beyond it.
        if (lsel < 70)
            r.list_limit = LIMIT_W'($urandom_range(8));
        else if (lsel < 90)
            r.list_limit = LIMIT_W'($urandom_range(64));
        else
            r.list_limit = LIMIT_W'($urandom_range(127));
        if (sel < 28)
            r.kind = KIND_CONNECT;
        else if (sel < 52)
            r.kind = KIND_READY;
        else if (sel < 62)
            r.kind = KIND_DISCONNECT;
        else if (sel < 70)
            r.kind = KIND_CLEAR;
        else if (sel < 74)
            r.kind = KIND_RESET_ALL;
        else if (sel < 78)
            r.kind = sel[0] ? KIND_SPARE_HI : KIND_SPARE_LO;
        else
            r.kind = KIND_LIST;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        set_client_count(MAX_CLIENTS);
        // Lists on an empty board: a zero limit, then a short limit.
        send_request(make_req(KIND_LIST, 0, 0));
        send_request(make_req(KIND_LIST, 0, 3));
        // Ready before connect is refused.
        send_request(make_req(KIND_READY, 5, 0));
        send_request(make_req(KIND_CONNECT, 0, 0));
        send_request(make_req(KIND_CONNECT, 0, 0));
        send_request(make_req(KIND_READY, 0, 0));
        send_request(make_req(KIND_CONNECT, 63, 0));
        send_request(make_req(KIND_READY, 63, 0));
        send_request(make_req(KIND_SPARE_LO, 63, 127));
        send_request(make_req(KIND_SPARE_HI, 0, 0));
        // A limit above the client count means no limit.
        send_request(make_req(KIND_LIST, 63, 127));
        send_request(make_req(KIND_DISCONNECT, 63, 0));
        send_request(make_req(KIND_CLEAR, 0, 0));
        send_request(make_req(KIND_DISCONNECT, 10, 0));
        send_request(make_req(KIND_CONNECT, 40, 0));
        send_request(make_req(KIND_READY, 40, 0));
        send_request(make_req(KIND_RESET_ALL, 0, 0));
        send_request(make_req(KIND_CONNECT, 40, 0));
        send_request(make_req(KIND_READY, 40, 0));
        release_request();

        // Two clients: the bits of client 40 stay counted above the count.
        set_client_count(2);
        send_request(make_req(KIND_CONNECT, 0, 0));
        send_request(make_req(KIND_CONNECT, 1, 0));
        send_request(make_req(KIND_READY, 0, 0));
        send_request(make_req(KIND_READY, 1, 0));
        send_request(make_req(KIND_LIST, 0, 64));
        send_request(make_req(KIND_CONNECT, 2, 0));
        release_request();

        // No clients at all: nothing is ready, nothing is in range.
        set_client_count(0);
        send_request(make_req(KIND_LIST, 0, 5));
        send_request(make_req(KIND_CONNECT, 0, 0));
        release_request();

        // An oversized count saturates at the maximum.
        set_client_count(127);
        send_request(make_req(KIND_LIST, 0, 70));
        release_request();
        wait_drain();
    endtask

    // Random traffic at one client count. Part of it brings clients up in
    // connect-then-ready pairs so that the all-ready flag is reached, with
    // plain random commands mixed in.
    task automatic test_random_traffic(input int count, input int n_items);
        int sent;
        int n;
        int c;
        set_client_count(count);
        n    = active_clients();
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 30 && n > 0)
            begin
                c = $urandom_range(n - 1);
                send_request(make_req(KIND_CONNECT, c, $urandom_range(127)));
                send_request(make_req(KIND_READY, c, $urandom_range(127)));
                sent += 2;
            end
            else
            begin
                send_request(random_request(n));
                sent++;
            end
        end
        release_request();
        wait_drain();
    endtask

    // The response side holds off for a long stretch while requests keep
    // coming, so the block has to stall its request channel.
    task automatic test_backpressure();
        set_client_count(MAX_CLIENTS);
        fork
            begin
                @(posedge clk);
                rsp_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 24; i++)
                begin
                    if (i % 3 == 0)
                        send_request(make_req(KIND_LIST, $urandom_range(63),
                                              $urandom_range(6)));
                    else
                        send_request(random_request(MAX_CLIENTS));
                end
                release_request();
            end
        join
        wait_drain();
    endtask

    task automatic set_idling(input int send_pct, input int rcv_pct);
        send_idle_pct = send_pct;
        rcv_idle_pct  = rcv_pct;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(7, 49);
        test_directed();
        test_random_traffic(64, 40);
        test_random_traffic(6, 40);

        set_idling(49, 7);
        test_random_traffic(1, 25);
        test_random_traffic(100, 40);

        set_idling(0, 0);
        test_random_traffic(12, 25);
        test_random_traffic(0, 15);
        test_random_traffic(3, 25);
        test_backpressure();

        wait_drain();
        repeat (20) @(posedge clk);
        if (owed_rsp_q.size() != 0)
            report_mismatch("responses left owed", 0, owed_rsp_q.size());

        $display("Covered %0d requests and %0d responses (%0d missing-client entries),",
                 requests_sent, rsp_checked, missing_seen);
        $display("client counts from 0 through 127, with idle, stall and hold-off phases.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
